// ===== sv/tsf_pkg.sv =====
package tsf_pkg;

   localparam logic [7:0]  SYNC_MARK         = 8'h47;
   localparam logic [7:0]  BASE_PACKET       = 8'd188;
   localparam logic [7:0]  MAX_PACKET        = 8'd208;
   localparam logic [7:0]  PACKET_SIZE_RESET = 8'd188;
   localparam logic [15:0] DROP_MAX          = 16'hFFFF;

   localparam logic        REG_PACKET_SIZE   = 1'b0;

   typedef struct packed {
      logic [15:0] discarded_count;
      logic        packet_start;
      logic [7:0]  out_byte;
   } tsf_result_type;

endpackage

// ===== sv/tsf_ram.sv =====
module tsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/tsf_tap_port.sv =====
module tsf_tap_port #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] ram_q;
   logic             bypass_ff;
   logic             bypass_in;
   logic [WIDTH-1:0] bypass_data_ff;

   tsf_ram #(
      .WIDTH (WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (ram_q)
   );

   // A read that hits the entry being written returns the new data.
   assign bypass_in = we && (waddr == raddr);

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff <= 1'b0;
      end else begin
         bypass_ff <= bypass_in;
      end
      bypass_data_ff <= wdata;
   end

   assign rdata = bypass_ff ? bypass_data_ff : ram_q;

endmodule

// ===== sv/tsf_core.sv =====
module tsf_core #(
   parameter int DEPTH = 512
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   input  logic                    item_flush,
   input  logic [7:0]              item_byte,
   input  logic [7:0]              cfg_size,
   input  logic [7:0]              cfg_size_next,
   output logic                    res_valid,
   output tsf_pkg::tsf_result_type res_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH + 1);
   localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(DEPTH);
   localparam logic [FW-1:0] FULL_FILL = FW'(DEPTH);
   localparam logic [AW-1:0] LAST_HEAD = AW'(DEPTH - 1);

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [AW-1:0] k);
      logic [AW:0] s;
      s = {1'b0, base} + {1'b0, k};
      if (s >= DEPTH_EXT) begin
         s = s - DEPTH_EXT;
      end
      return s[AW-1:0];
   endfunction

   function automatic logic [7:0] clamp_size(input logic [7:0] p);
      logic [7:0] r;
      r = p;
      if (p < tsf_pkg::BASE_PACKET) begin
         r = tsf_pkg::BASE_PACKET;
      end else if (p > tsf_pkg::MAX_PACKET) begin
         r = tsf_pkg::MAX_PACKET;
      end
      return r;
   endfunction

   logic [AW-1:0] head_ff, head_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [7:0]    body_ff, body_in;
   logic [15:0]   drop_ff, drop_in;

   logic          push;
   logic          pop;
   logic          ok;
   logic [FW-1:0] fill_p;
   logic [AW-1:0] waddr;
   logic          sync_new;

   logic [7:0]    psz;
   logic [9:0]    p10, off10, p_off10, pp_off10, need10;
   logic [9:0]    np10, noff10, np_off10, npp_off10;

   logic [AW-1:0] rd_head, rd_s0, rd_s1, rd_s2;
   logic [7:0]    q_head;
   logic          q_s0, q_s1, q_s2;
   logic [7:0]    head_byte;
   logic          s0, s1, s2;

   tsf_tap_port #(.WIDTH(8), .DEPTH(DEPTH)) u_head_port (
      .clock (clock), .reset (reset), .we (push), .waddr (waddr),
      .wdata (item_byte), .raddr (rd_head), .rdata (q_head)
   );

   tsf_tap_port #(.WIDTH(1), .DEPTH(DEPTH)) u_sync0_port (
      .clock (clock), .reset (reset), .we (push), .waddr (waddr),
      .wdata (sync_new), .raddr (rd_s0), .rdata (q_s0)
   );

   tsf_tap_port #(.WIDTH(1), .DEPTH(DEPTH)) u_sync1_port (
      .clock (clock), .reset (reset), .we (push), .waddr (waddr),
      .wdata (sync_new), .raddr (rd_s1), .rdata (q_s1)
   );

   tsf_tap_port #(.WIDTH(1), .DEPTH(DEPTH)) u_sync2_port (
      .clock (clock), .reset (reset), .we (push), .waddr (waddr),
      .wdata (sync_new), .raddr (rd_s2), .rdata (q_s2)
   );

   always_comb begin
      psz      = clamp_size(cfg_size);
      p10      = {2'b00, psz};
      off10    = p10 - 10'd188;
      p_off10  = p10 + off10;
      pp_off10 = p_off10 + p10;
      need10   = pp_off10 + 10'd1;

      np10      = {2'b00, clamp_size(cfg_size_next)};
      noff10    = np10 - 10'd188;
      np_off10  = np10 + noff10;
      npp_off10 = np_off10 + np10;

      push     = item_valid && !item_flush && (fill_ff != FULL_FILL);
      fill_p   = fill_ff + FW'(push);
      waddr    = wrap_add(head_ff, fill_ff[AW-1:0]);
      sync_new = (item_byte == tsf_pkg::SYNC_MARK);

      // The byte pushed in this transfer may itself sit on a tap.
      head_byte = (push && (fill_ff == '0)) ? item_byte : q_head;
      s0 = (push && (fill_ff == FW'(off10)))    ? sync_new : q_s0;
      s1 = (push && (fill_ff == FW'(p_off10)))  ? sync_new : q_s1;
      s2 = (push && (fill_ff == FW'(pp_off10))) ? sync_new : q_s2;

      if (drop_ff == '0) begin
         ok = (fill_p >= FW'(p10)) && s0;
      end else begin
         ok = (fill_p >= FW'(need10)) && s0 && s1 && s2;
      end

      head_in   = head_ff;
      fill_in   = fill_p;
      body_in   = body_ff;
      drop_in   = drop_ff;
      pop       = 1'b0;
      res_valid = 1'b0;
      res_data.out_byte        = head_byte;
      res_data.packet_start    = 1'b0;
      res_data.discarded_count = '0;

      if (item_valid) begin
         if (body_ff != '0) begin
            if (fill_p == '0) begin
               body_in = '0;
            end else begin
               pop       = 1'b1;
               res_valid = 1'b1;
               body_in   = body_ff - 8'd1;
            end
         end else if (ok) begin
            pop       = 1'b1;
            res_valid = 1'b1;
            res_data.packet_start    = 1'b1;
            res_data.discarded_count = drop_ff;
            drop_in   = '0;
            body_in   = psz - 8'd1;
         end else if (fill_p >= FW'(need10)) begin
            pop = 1'b1;
            if (drop_ff != tsf_pkg::DROP_MAX) begin
               drop_in = drop_ff + 16'd1;
            end
         end else if (item_flush) begin
            head_in = '0;
            fill_in = '0;
            body_in = '0;
            drop_in = '0;
         end
      end

      if (pop) begin
         head_in = (head_ff == LAST_HEAD) ? '0 : head_ff + AW'(1);
         fill_in = fill_p - FW'(1);
      end

      rd_head = head_in;
      rd_s0   = wrap_add(head_in, AW'(noff10));
      rd_s1   = wrap_add(head_in, AW'(np_off10));
      rd_s2   = wrap_add(head_in, AW'(npp_off10));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
         body_ff <= '0;
         drop_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
         body_ff <= body_in;
         drop_ff <= drop_in;
      end
   end

endmodule

// ===== sv/tsf_out_stage.sv =====
module tsf_out_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  tsf_pkg::tsf_result_type in_data,
   output logic                    in_ready,
   output logic                    out_valid,
   output tsf_pkg::tsf_result_type out_data,
   input  logic                    out_ready
);

   logic                    out_valid_ff;
   tsf_pkg::tsf_result_type out_data_ff;
   logic                    skid_valid_ff;
   tsf_pkg::tsf_result_type skid_data_ff;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= in_valid;
            out_data_ff  <= in_data;
         end
      end else if (in_valid) begin
         skid_valid_ff <= 1'b1;
         skid_data_ff  <= in_data;
      end
   end

endmodule

// ===== sv/ts_packet_sync_framer.sv =====
// Transport stream packet framer. Stream bytes enter on the req_ channel and the
// bytes of aligned packets leave on the rsp_ channel. A req_ transfer with tuser
// low pushes the byte in tdata; with tuser high it is a flush step that drains
// the window at the end of a stream. Each rsp_ transfer carries one packet byte,
// with tuser high on the first byte of a packet and the count of bytes dropped
// while hunting for sync in the upper tdata bits of that first byte.
// The user must set the packet size through the csr_ port at address 0 only
// while the block is idle; the block does not enforce this. Values below 188
// act as 188, values above 208 as 208. One req_ transfer is taken in every
// cycle while req_tready is high. A result is registered before it is offered
// on rsp_; many transfers cause none while the window fills or sync is being
// sought. The rate is set by the window memories, each read once per cycle at
// the head and at the three sync taps. Reset empties the window, ends any hunt
// and sets the packet size to 188; the window memories themselves are not
// cleared. When the receiver stalls, one further result is held in a skid
// register and req_tready then falls until the skid register drains.
module ts_packet_sync_framer #(
   parameter int WINDOW_DEPTH = 512
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // operation

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_byte, discarded_count
   output logic        rsp_tuser,   // packet_start

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0]              size_ff, size_in;
   logic                    csr_write;
   logic                    req_accept;
   logic                    res_valid;
   tsf_pkg::tsf_result_type res_data;
   tsf_pkg::tsf_result_type rsp_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign size_in    = (csr_write && (csr_paddr[2] == tsf_pkg::REG_PACKET_SIZE)) ?
                       csr_pwdata[7:0] : size_ff;
   assign csr_prdata = (csr_paddr[2] == tsf_pkg::REG_PACKET_SIZE) ?
                       {24'h000000, size_ff} : 32'h00000000;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= tsf_pkg::PACKET_SIZE_RESET;
      end else begin
         size_ff <= size_in;
      end
   end

   assign req_accept = req_tvalid && req_tready;

   tsf_core #(
      .DEPTH (WINDOW_DEPTH)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (req_accept),
      .item_flush    (req_tuser),
      .item_byte     (req_tdata),
      .cfg_size      (size_ff),
      .cfg_size_next (size_in),
      .res_valid     (res_valid),
      .res_data      (res_data)
   );

   tsf_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res_data),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_data),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {rsp_data.discarded_count, rsp_data.out_byte};
   assign rsp_tuser = rsp_data.packet_start;

endmodule
